>>> rtl/core/bsfd_pkg.sv
package bsfd_pkg;

  // Framing constants
  localparam logic [7:0] FLAG_DELIM = 8'h7E;
  localparam logic [7:0] FLAG_ESC   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [1:0] MIN_FRAME  = 2'd3;
  localparam logic [15:0] CRC_POLY  = 16'h8408;

  // Operations passed from the front end to the back end
  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_DATA  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_MISS  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } q_entry_t;

  // Status codes of end items
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_START = 2'd1,
    ST_SHORT    = 2'd2,
    ST_CRC_ERR  = 2'd3
  } status_t;

  // Front end phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_MSG  = 3'b010,
    PH_ESC  = 3'b100
  } phase_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

>>> rtl/core/bsfd_if.sv
interface bsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface bsfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic [1:0] status;

  modport source(output valid, output out_byte, output frame_end, output status, input ready);
  modport sink(input valid, input out_byte, input frame_end, input status, output ready);
endinterface

>>> rtl/core/bsfd_front.sv
module bsfd_front (
  input  logic                clk,
  input  logic                rst_n,
  bsfd_in_if.sink             in_ch,
  input  logic                q_full,
  output logic                push,
  output bsfd_pkg::q_entry_t  push_entry
);

  bsfd_pkg::phase_t phase_r, phase_nxt;
  logic             accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Classify the raw byte and advance the framing phase
  always_comb begin
    phase_nxt       = phase_r;
    push            = 1'b0;
    push_entry.op   = bsfd_pkg::OP_DATA;
    push_entry.data = in_ch.rx_byte;
    if (accept) begin
      unique case (phase_r)
        bsfd_pkg::PH_MSG: begin
          if (in_ch.rx_byte == bsfd_pkg::FLAG_ESC) begin
            phase_nxt = bsfd_pkg::PH_ESC;
          end else if (in_ch.rx_byte == bsfd_pkg::FLAG_DELIM) begin
            phase_nxt     = bsfd_pkg::PH_IDLE;
            push          = 1'b1;
            push_entry.op = bsfd_pkg::OP_CLOSE;
          end else begin
            push = 1'b1;
          end
        end
        bsfd_pkg::PH_ESC: begin
          phase_nxt       = bsfd_pkg::PH_MSG;
          push            = 1'b1;
          push_entry.data = in_ch.rx_byte ^ bsfd_pkg::ESC_XOR;
        end
        default: begin
          push = 1'b1;
          if (in_ch.rx_byte == bsfd_pkg::FLAG_DELIM) begin
            phase_nxt     = bsfd_pkg::PH_MSG;
            push_entry.op = bsfd_pkg::OP_OPEN;
          end else begin
            phase_nxt     = bsfd_pkg::PH_IDLE;
            push_entry.op = bsfd_pkg::OP_MISS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bsfd_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> rtl/core/bsfd_queue.sv
module bsfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bsfd_pkg::q_entry_t push_entry,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output bsfd_pkg::q_entry_t head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bsfd_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> rtl/core/bsfd_back.sv
module bsfd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  bsfd_pkg::q_entry_t head_entry,
  output logic               pop,
  bsfd_out_if.source         out_ch
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        frame_end_r, frame_end_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        step, emit;
  bsfd_pkg::status_t st;

  assign step = head_valid && (!out_valid_r || out_ch.ready);
  assign pop  = step;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.frame_end = frame_end_r;
  assign out_ch.status    = status_r;

  // Carry out one queued operation
  always_comb begin
    crc_nxt       = crc_r;
    held0_nxt     = held0_r;
    held1_nxt     = held1_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    out_byte_nxt  = out_byte_r;
    frame_end_nxt = frame_end_r;
    status_nxt    = status_r;
    st            = bsfd_pkg::ST_OK;
    if (step) begin
      unique case (head_entry.op)
        bsfd_pkg::OP_OPEN: begin
          crc_nxt = '0;
          cnt_nxt = '0;
        end
        bsfd_pkg::OP_DATA: begin
          crc_nxt = bsfd_pkg::crc_byte(crc_r, head_entry.data);
          if (cnt_r[1]) begin
            emit          = 1'b1;
            out_byte_nxt  = held0_r;
            frame_end_nxt = 1'b0;
            status_nxt    = bsfd_pkg::ST_OK;
            held0_nxt     = held1_r;
            held1_nxt     = head_entry.data;
            cnt_nxt       = 2'd3;
          end else begin
            if (cnt_r[0]) begin
              held1_nxt = head_entry.data;
            end else begin
              held0_nxt = head_entry.data;
            end
            cnt_nxt = cnt_r + 2'd1;
          end
        end
        bsfd_pkg::OP_CLOSE: begin
          if (cnt_r < bsfd_pkg::MIN_FRAME) begin
            st = bsfd_pkg::ST_SHORT;
          end else if (crc_r != '0) begin
            st = bsfd_pkg::ST_CRC_ERR;
          end else begin
            st = bsfd_pkg::ST_OK;
          end
          emit          = 1'b1;
          out_byte_nxt  = '0;
          frame_end_nxt = 1'b1;
          status_nxt    = st;
          cnt_nxt       = '0;
        end
        default: begin
          emit          = 1'b1;
          out_byte_nxt  = '0;
          frame_end_nxt = 1'b1;
          status_nxt    = bsfd_pkg::ST_NO_START;
        end
      endcase
    end
    // Hold the result until taken, load a new one on emit
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held0_r     <= held0_nxt;
    held1_r     <= held1_nxt;
    out_byte_r  <= out_byte_nxt;
    frame_end_r <= frame_end_nxt;
    status_r    <= status_nxt;
  end

endmodule

>>> rtl/core/byte_stuffed_frame_decoder_crc16.sv
// An accepted item passes through the queue, and its result is held in output registers.
// Accepts one byte per cycle while the queue is not full; the front-end framing FSM and
// the byte-wide CRC update in the back end are joined by a QDEPTH-entry queue.
// Reset (rst_n low, synchronous): framing waits for an opening delimiter, queue
// empties, CRC and hold count clear, output goes invalid. Held data is not cleared.
module byte_stuffed_frame_decoder_crc16 #(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  bsfd_in_if.sink     in_ch,
  bsfd_out_if.source  out_ch
);

  logic               q_full;
  logic               push;
  bsfd_pkg::q_entry_t push_entry;
  logic               pop;
  logic               head_valid;
  bsfd_pkg::q_entry_t head_entry;

  bsfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  bsfd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  bsfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

>>> tb/tb_byte_stuffed_frame_decoder_crc16.sv
`timescale 1ns / 100ps

module tb_byte_stuffed_frame_decoder_crc16;

  localparam int RAND_ITEMS  = 1350;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0]        data;
    logic              frame_end;
    bsfd_pkg::status_t status;
  } decoded_t;

  logic clk;
  logic rst_n;

  bsfd_in_if  in_if ();
  bsfd_out_if out_if ();

  byte_stuffed_frame_decoder_crc16 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Decoder state as the block should hold it
  bsfd_pkg::phase_t rx_phase;
  logic [15:0]      rx_crc;
  logic [7:0]       held [2];
  logic [1:0]       held_cnt;

  decoded_t decoded_q [$];

  int  errors;
  int  bytes_sent;
  int  frames_sent;
  int  payload_seen;
  int  end_tally [4];
  bit  idle_en;
  int  hold_req;
  int  quiet_cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reflected CRC-16, one bit at a time
  function automatic logic [15:0] kermit_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ bsfd_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  // Shift one data byte through the hold-back pair
  function automatic void hold_data(input logic [7:0] d);
    rx_crc = kermit_next(rx_crc, d);
    if (held_cnt >= 2'd2) begin
      decoded_q.push_back('{data: held[0], frame_end: 1'b0,
                            status: bsfd_pkg::ST_OK});
      held[0]  = held[1];
      held[1]  = d;
      held_cnt = 2'd3;
    end else begin
      held[held_cnt[0]] = d;
      held_cnt = held_cnt + 2'd1;
    end
  endfunction

  // Advance the decoder by one raw byte
  function automatic void deframe_byte(input logic [7:0] b);
    bsfd_pkg::status_t st;
    case (rx_phase)
      bsfd_pkg::PH_MSG: begin
        if (b == bsfd_pkg::FLAG_ESC) begin
          rx_phase = bsfd_pkg::PH_ESC;
        end else if (b == bsfd_pkg::FLAG_DELIM) begin
          if (held_cnt < bsfd_pkg::MIN_FRAME) begin
            st = bsfd_pkg::ST_SHORT;
          end else if (rx_crc != 16'h0000) begin
            st = bsfd_pkg::ST_CRC_ERR;
          end else begin
            st = bsfd_pkg::ST_OK;
          end
          rx_phase = bsfd_pkg::PH_IDLE;
          held_cnt = 2'd0;
          decoded_q.push_back('{data: 8'h00, frame_end: 1'b1, status: st});
        end else begin
          hold_data(b);
        end
      end
      bsfd_pkg::PH_ESC: begin
        rx_phase = bsfd_pkg::PH_MSG;
        hold_data(b ^ bsfd_pkg::ESC_XOR);
      end
      default: begin
        if (b == bsfd_pkg::FLAG_DELIM) begin
          rx_phase = bsfd_pkg::PH_MSG;
          rx_crc   = 16'h0000;
          held_cnt = 2'd0;
        end else begin
          rx_phase = bsfd_pkg::PH_IDLE;
          decoded_q.push_back('{data: 8'h00, frame_end: 1'b1,
                                status: bsfd_pkg::ST_NO_START});
        end
      end
    endcase
  endfunction

  // Offer one raw byte, with random gaps, and predict it once accepted
  task automatic push_byte(input logic [7:0] b);
    while (idle_en && $urandom_range(99) < 17) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Send a data byte, escaping delimiter and escape bytes and sometimes ordinary bytes
  task automatic push_data(input logic [7:0] d, input int esc_pct);
    if (d == bsfd_pkg::FLAG_DELIM || d == bsfd_pkg::FLAG_ESC ||
        $urandom_range(99) < esc_pct) begin
      push_byte(bsfd_pkg::FLAG_ESC);
      push_byte(d ^ bsfd_pkg::ESC_XOR);
    end else begin
      push_byte(d);
    end
  endtask

  // Send a whole frame: open, stuffed payload, CRC low byte first, close
  task automatic push_frame(input logic [7:0] pay [$], input bit crc_good, input int esc_pct);
    logic [15:0] c;
    c = 16'h0000;
    foreach (pay[i]) begin
      c = kermit_next(c, pay[i]);
    end
    if (!crc_good) begin
      c = c ^ (16'h0001 << $urandom_range(15));
    end
    push_byte(bsfd_pkg::FLAG_DELIM);
    foreach (pay[i]) begin
      push_data(pay[i], esc_pct);
    end
    push_data(c[7:0], esc_pct);
    push_data(c[15:8], esc_pct);
    push_byte(bsfd_pkg::FLAG_DELIM);
    frames_sent++;
  endtask

  // Build a random payload, mostly short
  function automatic void fill_payload(ref logic [7:0] pay [$]);
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
    pay.delete();
    for (int i = 0; i < len; i++) begin
      pay.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Extremes, every status code and the escape corner cases
  task automatic test_directed();
    logic [7:0] pay [$];
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(bsfd_pkg::FLAG_ESC);
    push_byte(bsfd_pkg::FLAG_DELIM);
    push_byte(bsfd_pkg::FLAG_DELIM);
    push_byte(bsfd_pkg::FLAG_DELIM);
    push_byte(8'h41);
    push_byte(8'h12);
    push_byte(bsfd_pkg::FLAG_DELIM);
    pay = '{8'h00};
    push_frame(pay, 1'b1, 0);
    pay = '{8'hFF};
    push_frame(pay, 1'b1, 0);
    pay = '{bsfd_pkg::FLAG_DELIM, bsfd_pkg::FLAG_ESC};
    push_frame(pay, 1'b1, 0);
    pay = '{8'h55};
    push_frame(pay, 1'b0, 0);
  endtask

  // Frames back to back with no idling on either side
  task automatic test_steady_stream();
    logic [7:0] pay [$];
    idle_en = 1'b0;
    for (int n = 0; n < 12; n++) begin
      fill_payload(pay);
      push_frame(pay, $urandom_range(3) != 0, 10);
    end
    idle_en = 1'b1;
  endtask

  // Stall the receiver while a long frame keeps coming
  task automatic test_backpressure();
    logic [7:0] pay [$];
    pay.delete();
    for (int i = 0; i < 30; i++) begin
      pay.push_back(8'($urandom_range(255)));
    end
    hold_req = HOLD_CYCLES;
    push_frame(pay, 1'b1, 5);
  endtask

  // Mostly well-formed frames, with noise and broken frames mixed in
  task automatic test_random_traffic();
    logic [7:0] pay [$];
    int         pick;
    while (bytes_sent < RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        fill_payload(pay);
        push_frame(pay, $urandom_range(3) != 0, $urandom_range(1) ? 0 : 15);
      end else if (pick < 88) begin
        // noise between frames, biased to the framing codes
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(3))
            0:       push_byte(bsfd_pkg::FLAG_DELIM);
            1:       push_byte(bsfd_pkg::FLAG_ESC);
            default: push_byte(8'($urandom_range(255)));
          endcase
        end
      end else begin
        // broken frame: random raw body, sometimes an escape right before the close
        push_byte(bsfd_pkg::FLAG_DELIM);
        repeat ($urandom_range(0, 8)) begin
          push_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(1)) begin
          push_byte(bsfd_pkg::FLAG_ESC);
        end
        push_byte(bsfd_pkg::FLAG_DELIM);
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_if.ready <= 1'b0;
        hold_req--;
      end else if (idle_en) begin
        out_if.ready <= ($urandom_range(99) >= 17);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (out_if.frame_end) begin
        end_tally[out_if.status]++;
      end else begin
        payload_seen++;
      end
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte=%h frame_end=%b status=%0d",
               out_if.out_byte, out_if.frame_end, out_if.status);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_if.out_byte !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_if.out_byte);
          errors++;
        end
        if (out_if.frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, out_if.frame_end);
          errors++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("byte_stuffed_frame_decoder_crc16: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.rx_byte <= 8'h00;
    rx_phase     = bsfd_pkg::PH_IDLE;
    rx_crc       = 16'h0000;
    held_cnt     = 2'd0;
    errors       = 0;
    bytes_sent   = 0;
    frames_sent  = 0;
    payload_seen = 0;
    end_tally    = '{0, 0, 0, 0};
    idle_en      = 1'b1;
    hold_req     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_steady_stream();
    test_backpressure();
    test_random_traffic();
    in_if.valid <= 1'b0;

    // Drain whatever is still in flight
    while (decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);

    $display("Run: %0d raw bytes, %0d framed sends, %0d payload bytes out",
             bytes_sent, frames_sent, payload_seen);
    $display("End items: ok %0d, no start %0d, too short %0d, crc error %0d",
             end_tally[bsfd_pkg::ST_OK], end_tally[bsfd_pkg::ST_NO_START],
             end_tally[bsfd_pkg::ST_SHORT], end_tally[bsfd_pkg::ST_CRC_ERR]);
    if (errors == 0) begin
      $display("byte_stuffed_frame_decoder_crc16: match");
    end else begin
      $display("byte_stuffed_frame_decoder_crc16: mismatch");
    end
    $finish;
  end

endmodule
